@@ design/mbp_pkg.sv @@
// ----------------------------------------------------------------------------
// mbp_pkg
// types and constants shared by the msb-first bit packer
// ----------------------------------------------------------------------------
package mbp_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int WIDTH_BITS  = 6;
   localparam int BYTE_BITS   = 8;
   localparam int STREAM_BITS = 40;   // up to 7 pending bits plus a 32-bit field, five bytes wide
   localparam int COUNT_BITS  = 3;    // zero to five bytes per item
   localparam int POS_BITS    = 3;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [VALUE_BITS-1:0] field_value;
      logic [WIDTH_BITS-1:0] field_width;
      logic                  flush;
   } req_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      logic                 last_of_run;
   } rsp_type;

   // one packed run of bytes, earliest byte in the top bits
   typedef struct packed {
      logic [STREAM_BITS-1:0] bytes;
      logic [COUNT_BITS-1:0]  count;
   } job_type;

   typedef struct packed {
      logic can_push;
      logic has_data;
   } q_status_type;

   function automatic logic [BYTE_BITS-1:0] pick_byte(
      input logic [STREAM_BITS-1:0] bytes,
      input logic [COUNT_BITS-1:0]  idx
   );
      logic [BYTE_BITS-1:0] result;
      case (idx)
         3'd0:    result = bytes[39:32];
         3'd1:    result = bytes[31:24];
         3'd2:    result = bytes[23:16];
         3'd3:    result = bytes[15:8];
         3'd4:    result = bytes[7:0];
         default: result = '0;
      endcase
      return result;
   endfunction

endpackage

@@ design/mbp_front.sv @@
// ----------------------------------------------------------------------------
// mbp_front
// takes input beats, merges each field into the pending byte, hands full runs on
// ----------------------------------------------------------------------------
module mbp_front #(
   parameter int MAX_FIELD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  mbp_pkg::req_type      req_data,
   output logic                  req_stall,
   input  mbp_pkg::q_status_type q_status,
   output logic                  push,
   output mbp_pkg::job_type      push_job
);

   localparam int LIMIT = (MAX_FIELD_BITS < mbp_pkg::VALUE_BITS) ? MAX_FIELD_BITS
                                                                 : mbp_pkg::VALUE_BITS;

   logic [mbp_pkg::BYTE_BITS-1:0]   pending_ff, pending_in;
   logic [mbp_pkg::POS_BITS-1:0]    pos_ff, pos_in;
   logic                            accept;
   logic [mbp_pkg::WIDTH_BITS-1:0]  width_sat;
   logic [mbp_pkg::VALUE_BITS-1:0]  masked;
   logic [mbp_pkg::WIDTH_BITS-1:0]  total;
   logic [mbp_pkg::WIDTH_BITS-1:0]  shift;
   logic [mbp_pkg::STREAM_BITS-1:0] stream;
   logic [mbp_pkg::COUNT_BITS-1:0]  full_bytes;
   logic [mbp_pkg::POS_BITS-1:0]    rem_bits;
   logic                            pad;

   assign req_stall = !q_status.can_push;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      width_sat = (req_data.field_width > mbp_pkg::WIDTH_BITS'(LIMIT))
                  ? mbp_pkg::WIDTH_BITS'(LIMIT) : req_data.field_width;
      // a shift of 32 or more clears the word, so width 32 keeps every bit
      masked = req_data.field_value & ~({mbp_pkg::VALUE_BITS{1'b1}} << width_sat);
      total  = {{(mbp_pkg::WIDTH_BITS-mbp_pkg::POS_BITS){1'b0}}, pos_ff} + width_sat;
      shift  = mbp_pkg::WIDTH_BITS'(mbp_pkg::STREAM_BITS) - total;
      stream = {pending_ff, {mbp_pkg::VALUE_BITS{1'b0}}}
             | ({{(mbp_pkg::STREAM_BITS-mbp_pkg::VALUE_BITS){1'b0}}, masked} << shift);
      full_bytes = total[mbp_pkg::WIDTH_BITS-1:mbp_pkg::POS_BITS];
      rem_bits   = total[mbp_pkg::POS_BITS-1:0];
      pad        = req_data.flush && (rem_bits != '0);
   end

   always_comb begin
      push_job.bytes = stream;
      push_job.count = full_bytes + {{(mbp_pkg::COUNT_BITS-1){1'b0}}, pad};
      push           = accept && (push_job.count != '0);
   end

   always_comb begin
      pending_in = pending_ff;
      pos_in     = pos_ff;
      if (accept) begin
         if (req_data.flush) begin
            pending_in = '0;
            pos_in     = '0;
         end else begin
            // low bits under the stream are already zero
            pending_in = mbp_pkg::pick_byte(stream, full_bytes);
            pos_in     = rem_bits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         pos_ff     <= '0;
      end else begin
         pending_ff <= pending_in;
         pos_ff     <= pos_in;
      end
   end

endmodule

@@ design/mbp_queue.sv @@
// ----------------------------------------------------------------------------
// mbp_queue
// short register queue of byte runs between front and back
// ----------------------------------------------------------------------------
module mbp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mbp_pkg::job_type      push_job,
   input  logic                  pop,
   output mbp_pkg::job_type      head_job,
   output mbp_pkg::q_status_type q_status
);

   localparam int PTR_BITS = (mbp_pkg::QUEUE_DEPTH > 1) ? $clog2(mbp_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(mbp_pkg::QUEUE_DEPTH + 1);

   mbp_pkg::job_type    entries_ff [mbp_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign q_status.can_push = (count_ff != CNT_BITS'(mbp_pkg::QUEUE_DEPTH));
   assign q_status.has_data = (count_ff != '0);
   assign head_job          = entries_ff[rd_ptr_ff];
   assign do_push           = push && q_status.can_push;
   assign do_pop            = pop && q_status.has_data;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(mbp_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(mbp_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/mbp_back.sv @@
// ----------------------------------------------------------------------------
// mbp_back
// walks the head run byte by byte into the output register
// ----------------------------------------------------------------------------
module mbp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  mbp_pkg::job_type      head_job,
   input  mbp_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   output mbp_pkg::rsp_type      rsp_data,
   input  logic                  rsp_stall
);

   logic                           rsp_valid_ff, rsp_valid_in;
   mbp_pkg::rsp_type               rsp_ff, rsp_in;
   logic [mbp_pkg::COUNT_BITS-1:0] idx_ff, idx_in;
   logic                           advance;
   logic                           is_last;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign is_last   = (idx_ff == head_job.count - mbp_pkg::COUNT_BITS'(1));
   assign pop       = advance && q_status.has_data && is_last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      idx_in       = idx_ff;
      if (advance) begin
         rsp_valid_in = q_status.has_data;
         if (q_status.has_data) begin
            rsp_in.out_byte    = mbp_pkg::pick_byte(head_job.bytes, idx_ff);
            rsp_in.last_of_run = is_last;
            idx_in             = is_last ? '0 : idx_ff + mbp_pkg::COUNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

endmodule

@@ design/msb_first_bit_packer_unit.sv @@
// ----------------------------------------------------------------------------
// msb_first_bit_packer_unit
// packs variable-width fields into a byte stream, most significant bit first
// ----------------------------------------------------------------------------
//
//   channel | direction | beat carries                          | handshake
//   --------+-----------+---------------------------------------+------------------
//   req_    | in        | field_value, field_width, flush       | valid / stall
//   rsp_    | out       | out_byte, last_of_run                 | valid / stall
//
// an input beat is merged into the pending byte in the cycle it is taken;
// a new beat can be taken every cycle while the run queue has room
// bytes pass the run queue and then the output register, leaving at one per cycle
// while rsp_stall is low; new beats are taken while older runs still drain,
// and an item makes up to five bytes, four sustained for full fields
// reset (synchronous) empties the queue and clears the pending byte and position
// an output stall holds the current byte; req_stall rises only when the queue is full
//
module msb_first_bit_packer_unit #(
   parameter int MAX_FIELD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  mbp_pkg::req_type req_data,
   output logic             req_stall,
   output logic             rsp_valid,
   output mbp_pkg::rsp_type rsp_data,
   input  logic             rsp_stall
);

   // front to back plumbing
   logic                  push;
   logic                  pop;
   mbp_pkg::job_type      push_job;
   mbp_pkg::job_type      head_job;
   mbp_pkg::q_status_type q_status;

   // front: width saturation, bit merge, pending byte state
   mbp_front #(
      .MAX_FIELD_BITS(MAX_FIELD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   // runs of completed bytes, items with no bytes are never queued
   mbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   // back: one byte per cycle while rsp_stall is low, last byte of each run flagged
   mbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

@@ design/mbp_checker.sv @@
// ----------------------------------------------------------------------------
// mbp_checker
// port-level checks on the bit packer, bound to the top level
// ----------------------------------------------------------------------------
module mbp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input mbp_pkg::req_type req_data,
   input logic             req_stall,
   input logic             rsp_valid,
   input mbp_pkg::rsp_type rsp_data,
   input logic             rsp_stall
);

   // stalled input beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled req beat changed");

   // stalled output beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   // a run is sent without gaps up to its last byte
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_of_run |=> rsp_valid)
      else $error("gap inside a byte run");

   // reset leaves nothing to send
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // reset leaves the queue open for input
   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("req stalled after reset");

endmodule

bind msb_first_bit_packer_unit mbp_checker u_mbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_data  (req_data),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .rsp_stall (rsp_stall)
);
